// ===== src/binary_rectangle_region_stats_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle region statistics block.
// Each macro expects signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef BINARY_RECTANGLE_REGION_STATS_MACROS_SVH
`define BINARY_RECTANGLE_REGION_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BRRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BRRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/brrs_pkg.sv =====
// ----------------------------------------------------------------------------
// brrs_pkg
// Shared types and constants of the rectangle region statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package brrs_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_ROWS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_COLS = 1'd1;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;

    // Result field widths
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int AREA_W = 13;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    localparam int NUM_KINDS = 3;

    typedef enum logic [1:0] {
        KIND_WIDTH  = 2'd0,
        KIND_AREA   = 2'd1,
        KIND_HEIGHT = 2'd2
    } measure_kind_t;

    typedef enum logic {
        EV_OFFER = 1'b0,
        EV_FLUSH = 1'b1
    } ev_kind_t;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FLUSH = 3'b100
    } front_state_t;

endpackage

`default_nettype wire

// ===== src/brrs_channels.sv =====
// ----------------------------------------------------------------------------
// brrs channels
// Valid/ready channels of the block: pixel input, register writes, results.
// ----------------------------------------------------------------------------
`default_nettype none

interface brrs_pixel_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface brrs_cfg_if;
    import brrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

interface brrs_result_if;
    import brrs_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        measure_kind;
    logic              found;
    logic [POS_W-1:0]  top_row;
    logic [POS_W-1:0]  left_col;
    logic [LEN_W-1:0]  rect_width;
    logic [LEN_W-1:0]  rect_height;
    logic [AREA_W-1:0] rect_area;
    logic              last;

    modport source (output valid, output measure_kind, output found, output top_row,
                    output left_col, output rect_width, output rect_height,
                    output rect_area, output last, input ready);
    modport sink   (input valid, input measure_kind, input found, input top_row,
                    input left_col, input rect_width, input rect_height,
                    input rect_area, input last, output ready);
endinterface

`default_nettype wire

// ===== src/brrs_front.sv =====
// ----------------------------------------------------------------------------
// brrs_front
// Raster tracker: takes pixels, finds corners, tracks row runs and open
// columns, and posts finished rectangles and end-of-image marks as words.
// ----------------------------------------------------------------------------
`default_nettype none

module brrs_front
    import brrs_pkg::*;
#(
    parameter int  MAX_DIM = 64,
    parameter type evt_t   = logic
)
(
    input  logic              clk,
    input  logic              rst_n,
    brrs_pixel_if.sink        pixels,
    brrs_cfg_if.sink          cfg,
    output evt_t              evt,
    output logic              evt_push,
    input  logic              q_full
);

    localparam int DW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_DIM + 1);
    localparam logic [DW-1:0] LAST_COL = DW'(MAX_DIM - 1);

    front_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] rows_cfg_reg;
    logic [CFG_DATA_W-1:0] cols_cfg_reg;
    logic [LW-1:0]         rows_eff;
    logic [LW-1:0]         cols_eff;

    logic [DW-1:0]      row_reg, row_next;
    logic [DW-1:0]      col_reg, col_next;
    logic               left_reg, left_next;
    logic [DW-1:0]      run_col_reg, run_col_next;
    logic [LW-1:0]      run_len_reg, run_len_next;
    logic               run_corner_reg, run_corner_next;
    logic [MAX_DIM-1:0] above_reg, above_next;
    logic [MAX_DIM-1:0] open_reg, open_next;
    logic [DW-1:0]      sweep_reg, sweep_next;

    // Corner row and width of each open column
    logic [DW-1:0] start_mem [MAX_DIM];
    logic [LW-1:0] width_mem [MAX_DIM];
    logic [DW-1:0] start_rd_reg;
    logic [LW-1:0] width_rd_reg;
    logic [DW-1:0] rd_addr;

    logic          start_we;
    logic          width_we;
    logic [DW-1:0] width_wa;
    logic [LW-1:0] width_wd;

    logic          pix;
    logic          pix_acc;
    logic [LW-1:0] col_plus;
    logic [LW-1:0] row_plus;
    logic          row_end;
    logic          img_end;
    logic          corner;
    logic          close_c;
    logic          finish;
    logic          open_k;
    logic          adv;
    logic [DW-1:0] run_col_cur;
    logic [LW-1:0] run_len_cur;
    logic          run_corner_cur;

    function automatic logic [LW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return LW'(1);
        else if (32'(v) > 32'(MAX_DIM))
            return LW'(MAX_DIM);
        else
            return LW'(v);
    endfunction

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= DIM_RESET;
            cols_cfg_reg <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_IMAGE_ROWS: rows_cfg_reg <= cfg.data;
                REG_IMAGE_COLS: cols_cfg_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign rows_eff = eff_dim(rows_cfg_reg);
    assign cols_eff = eff_dim(cols_cfg_reg);

    // Classify the pixel at the current raster position
    always_comb
    begin
        pix      = pixels.pixel;
        col_plus = LW'(col_reg) + LW'(1);
        row_plus = LW'(row_reg) + LW'(1);
        row_end  = col_plus >= cols_eff;
        img_end  = row_end && (row_plus >= rows_eff);
        corner   = pix && !above_reg[col_reg] && !left_reg;
        close_c  = open_reg[col_reg] && !pix;

        if (pix && !left_reg)
        begin
            run_col_cur    = col_reg;
            run_len_cur    = LW'(1);
            run_corner_cur = corner;
        end
        else if (pix)
        begin
            run_col_cur    = run_col_reg;
            run_len_cur    = run_len_reg + LW'(1);
            run_corner_cur = run_corner_reg;
        end
        else
        begin
            run_col_cur    = run_col_reg;
            run_len_cur    = run_len_reg;
            run_corner_cur = run_corner_reg;
        end

        finish = (!pix && left_reg) || (row_end && pix);
    end

    // Sequence pixels, the end-of-image sweep and the flush mark
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        left_next       = left_reg;
        run_col_next    = run_col_reg;
        run_len_next    = run_len_reg;
        run_corner_next = run_corner_reg;
        above_next      = above_reg;
        open_next       = open_reg;
        sweep_next      = sweep_reg;
        rd_addr         = col_reg;
        pixels.ready    = 1'b0;
        pix_acc         = 1'b0;
        start_we        = 1'b0;
        width_we        = 1'b0;
        width_wa        = col_reg;
        width_wd        = LW'(1);
        evt_push        = 1'b0;
        open_k          = open_reg[sweep_reg];
        adv             = 1'b0;
        evt.kind        = EV_OFFER;
        evt.row         = start_rd_reg;
        evt.col         = col_reg;
        evt.w           = width_rd_reg;
        evt.h           = LW'(row_reg) - LW'(start_rd_reg);

        case (state_reg)
            ST_RUN:
            begin
                pixels.ready = !q_full;
                pix_acc      = pixels.valid && !q_full;
                if (pix_acc)
                begin
                    evt_push = close_c;
                    start_we = corner;
                    width_we = corner || (finish && run_corner_cur);
                    if (finish && run_corner_cur)
                    begin
                        width_wa = run_col_cur;
                        width_wd = run_len_cur;
                    end

                    above_next[col_reg] = pix;
                    if (close_c)
                        open_next[col_reg] = 1'b0;
                    else if (corner)
                        open_next[col_reg] = 1'b1;

                    run_col_next    = run_col_cur;
                    run_corner_next = run_corner_cur;
                    run_len_next    = finish ? '0 : run_len_cur;

                    if (row_end)
                    begin
                        col_next  = '0;
                        left_next = 1'b0;
                        if (img_end)
                            state_next = ST_SWEEP;
                        else
                            row_next = row_reg + DW'(1);
                    end
                    else
                    begin
                        col_next  = col_reg + DW'(1);
                        left_next = pix;
                    end
                    rd_addr = col_next;
                end
            end

            ST_SWEEP:
            begin
                evt.col = sweep_reg;
                evt.h   = row_plus - LW'(start_rd_reg);
                evt_push = open_k && !q_full;
                adv      = !open_k || !q_full;
                rd_addr  = sweep_reg;
                if (adv)
                begin
                    if (sweep_reg == LAST_COL)
                    begin
                        state_next = ST_FLUSH;
                        sweep_next = '0;
                        rd_addr    = '0;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + DW'(1);
                        rd_addr    = sweep_next;
                    end
                end
            end

            ST_FLUSH:
            begin
                rd_addr  = '0;
                evt.kind = EV_FLUSH;
                evt_push = !q_full;
                if (!q_full)
                begin
                    state_next      = ST_RUN;
                    above_next      = '0;
                    open_next       = '0;
                    row_next        = '0;
                    col_next        = '0;
                    left_next       = 1'b0;
                    run_col_next    = '0;
                    run_len_next    = '0;
                    run_corner_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Hold raster and flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            row_reg        <= '0;
            col_reg        <= '0;
            left_reg       <= 1'b0;
            run_col_reg    <= '0;
            run_len_reg    <= '0;
            run_corner_reg <= 1'b0;
            above_reg      <= '0;
            open_reg       <= '0;
            sweep_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            left_reg       <= left_next;
            run_col_reg    <= run_col_next;
            run_len_reg    <= run_len_next;
            run_corner_reg <= run_corner_next;
            above_reg      <= above_next;
            open_reg       <= open_next;
            sweep_reg      <= sweep_next;
        end
    end

    // Column tables: one write each, registered write-first read
    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[col_reg] <= row_reg;
        if (width_we)
            width_mem[width_wa] <= width_wd;

        if (start_we && (col_reg == rd_addr))
            start_rd_reg <= row_reg;
        else
            start_rd_reg <= start_mem[rd_addr];

        if (width_we && (width_wa == rd_addr))
            width_rd_reg <= width_wd;
        else
            width_rd_reg <= width_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/brrs_queue.sv =====
// ----------------------------------------------------------------------------
// brrs_queue
// Short first-in first-out queue of words between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module brrs_queue
    import brrs_pkg::*;
#(
    parameter type T = logic
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     push_data,
    output logic full,
    input  logic pop,
    output T     head,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    T              slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== src/brrs_back.sv =====
// ----------------------------------------------------------------------------
// brrs_back
// Record keeper: computes areas, keeps the best record per measure and
// sends the three records of an image when its flush mark arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module brrs_back
    import brrs_pkg::*;
#(
    parameter int  MAX_DIM = 64,
    parameter type evt_t   = logic
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  evt_t              q_head,
    input  logic              q_empty,
    output logic              q_pop,
    brrs_result_if.source     results
);

    localparam int DW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * LW;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] row;
        logic [DW-1:0] col;
        logic [LW-1:0] w;
        logic [LW-1:0] h;
        logic [AW-1:0] area;
    } rec_t;

    logic          s1_valid_reg;
    evt_t          s1_evt_reg;
    logic [AW-1:0] s1_area_reg;
    logic          s1_consume;

    rec_t          best_reg [NUM_KINDS];
    rec_t          emit_buf_reg [NUM_KINDS];
    logic          emit_valid_reg;
    measure_kind_t emit_idx_reg;
    measure_kind_t emit_idx_next;

    rec_t                 cand;
    rec_t                 cur;
    logic [NUM_KINDS-1:0] take;
    logic                 out_acc;
    logic                 load_emit;

    function automatic logic [AW-1:0] measure_of(input rec_t r, input measure_kind_t k);
        case (k)
            KIND_WIDTH: return AW'(r.w);
            KIND_AREA:  return r.area;
            default:    return AW'(r.h);
        endcase
    endfunction

    // Drain the queue into the multiply stage
    assign s1_consume = s1_valid_reg && ((s1_evt_reg.kind == EV_OFFER) || !emit_valid_reg);
    assign q_pop      = !q_empty && (!s1_valid_reg || s1_consume);
    assign load_emit  = s1_consume && (s1_evt_reg.kind == EV_FLUSH);

    // Compare the candidate against each kept record
    always_comb
    begin
        cand.valid = 1'b1;
        cand.row   = s1_evt_reg.row;
        cand.col   = s1_evt_reg.col;
        cand.w     = s1_evt_reg.w;
        cand.h     = s1_evt_reg.h;
        cand.area  = s1_area_reg;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            if (!best_reg[k].valid)
                take[k] = 1'b1;
            else if (measure_of(cand, measure_kind_t'(2'(k))) >
                     measure_of(best_reg[k], measure_kind_t'(2'(k))))
                take[k] = 1'b1;
            else if (measure_of(cand, measure_kind_t'(2'(k))) ==
                     measure_of(best_reg[k], measure_kind_t'(2'(k))))
                take[k] = (cand.row < best_reg[k].row) ||
                          ((cand.row == best_reg[k].row) && (cand.col < best_reg[k].col));
            else
                take[k] = 1'b0;
        end
    end

    // Step through the three records
    always_comb
    begin
        case (emit_idx_reg)
            KIND_WIDTH: emit_idx_next = KIND_AREA;
            KIND_AREA:  emit_idx_next = KIND_HEIGHT;
            default:    emit_idx_next = KIND_WIDTH;
        endcase
    end

    assign out_acc = results.valid && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            emit_valid_reg <= 1'b0;
            emit_idx_reg   <= KIND_WIDTH;
            for (int k = 0; k < NUM_KINDS; k++)
                best_reg[k] <= '0;
        end
        else
        begin
            if (q_pop)
                s1_valid_reg <= 1'b1;
            else if (s1_consume)
                s1_valid_reg <= 1'b0;

            // Update or hand off the kept records
            if (load_emit)
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                    best_reg[k] <= '0;
            end
            else if (s1_consume)
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                    if (take[k])
                        best_reg[k] <= cand;
            end

            if (load_emit)
            begin
                emit_valid_reg <= 1'b1;
                emit_idx_reg   <= KIND_WIDTH;
            end
            else if (out_acc)
            begin
                emit_idx_reg <= emit_idx_next;
                if (emit_idx_reg == KIND_HEIGHT)
                    emit_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: word, area product, record snapshot
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_evt_reg  <= q_head;
            s1_area_reg <= AW'(q_head.w) * AW'(q_head.h);
        end
        if (load_emit)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
                emit_buf_reg[k] <= best_reg[k];
        end
    end

    // Drive the result word
    assign cur = emit_buf_reg[emit_idx_reg];

    assign results.valid        = emit_valid_reg;
    assign results.measure_kind = emit_idx_reg;
    assign results.found        = cur.valid;
    assign results.top_row      = cur.valid ? POS_W'(cur.row) : '0;
    assign results.left_col     = cur.valid ? POS_W'(cur.col) : '0;
    assign results.rect_width   = cur.valid ? LEN_W'(cur.w) : '0;
    assign results.rect_height  = cur.valid ? LEN_W'(cur.h) : '0;
    assign results.rect_area    = cur.valid ? AREA_W'(cur.area) : '0;
    assign results.last         = emit_idx_reg == KIND_HEIGHT;

endmodule

`default_nettype wire

// ===== src/binary_rectangle_region_stats.sv =====
// ----------------------------------------------------------------------------
// binary_rectangle_region_stats
// Finds filled rectangles in a raster binary image and reports the widest,
// the largest and the tallest one after the last pixel.
//
// Channel  Dir  Payload                                       Accept
// pixels   in   pixel                                         valid && ready
// cfg      in   addr (0 rows, 1 cols), data                   valid && ready
// results  out  measure_kind, found, top_row, left_col,       valid && ready
//               rect_width, rect_height, rect_area, last
//
// One pixel per cycle; pixels.ready drops while the word queue is full.
// After the last pixel of an image, pixels.ready stays low during a sweep
// over all MAX_DIM entries of the open-column table and the flush mark,
// and longer while the queue is full.
// Results: three words per image, from a snapshot, so the next image runs on.
// Reset: asynchronous rst_n clears control and flags; column tables unreset.
// Register writes are taken every cycle and act at once.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_rectangle_region_stats
    import brrs_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    brrs_pixel_if.sink    pixels,
    brrs_cfg_if.sink      cfg,
    brrs_result_if.source results
);

    localparam int DW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_DIM + 1);

    typedef struct packed {
        ev_kind_t      kind;
        logic [DW-1:0] row;
        logic [DW-1:0] col;
        logic [LW-1:0] w;
        logic [LW-1:0] h;
    } evt_t;

    evt_t push_evt;
    evt_t head_evt;
    logic push;
    logic full;
    logic pop;
    logic empty;

    brrs_front #(
        .MAX_DIM (MAX_DIM),
        .evt_t   (evt_t)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .cfg      (cfg),
        .evt      (push_evt),
        .evt_push (push),
        .q_full   (full)
    );

    brrs_queue #(
        .T (evt_t)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_evt),
        .full      (full),
        .pop       (pop),
        .head      (head_evt),
        .empty     (empty)
    );

    brrs_back #(
        .MAX_DIM (MAX_DIM),
        .evt_t   (evt_t)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (head_evt),
        .q_empty (empty),
        .q_pop   (pop),
        .results (results)
    );

endmodule

`default_nettype wire

// ===== src/brrs_checker.sv =====
// ----------------------------------------------------------------------------
// brrs_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_rectangle_region_stats_macros.svh"

module brrs_checker
    import brrs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        measure_kind,
    input wire logic              found,
    input wire logic [POS_W-1:0]  top_row,
    input wire logic [POS_W-1:0]  left_col,
    input wire logic [LEN_W-1:0]  rect_width,
    input wire logic [LEN_W-1:0]  rect_height,
    input wire logic [AREA_W-1:0] rect_area,
    input wire logic              last
);

    // Hold a stalled word
    `BRRS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(measure_kind) && $stable(found) && $stable(top_row) && $stable(left_col) && $stable(rect_width) && $stable(rect_height) && $stable(rect_area) && $stable(last), "stalled result word changed")

    // Mark the height record, and only it, as last
    `BRRS_ASSERT_NOW(a_last_kind, out_valid, last == (measure_kind == KIND_HEIGHT), "last flag does not match measure kind")

    // Clear every field of an empty record
    `BRRS_ASSERT_NOW(a_empty_zero, out_valid && !found, (top_row == '0) && (left_col == '0) && (rect_width == '0) && (rect_height == '0) && (rect_area == '0), "empty record carries data")

    // Advance through the records of one image without a gap
    `BRRS_ASSERT_NEXT(a_kind_step, out_valid && out_ready && !last, out_valid && (measure_kind == $past(measure_kind) + 2'd1), "records out of order")

    // Agree on found across the records of one image
    `BRRS_ASSERT_NEXT(a_found_same, out_valid && out_ready && !last, found == $past(found), "found differs within an image")

endmodule

bind binary_rectangle_region_stats brrs_checker u_brrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .measure_kind (results.measure_kind),
    .found        (results.found),
    .top_row      (results.top_row),
    .left_col     (results.left_col),
    .rect_width   (results.rect_width),
    .rect_height  (results.rect_height),
    .rect_area    (results.rect_area),
    .last         (results.last)
);

`default_nettype wire

// ===== test/binary_rectangle_region_stats_tb.sv =====
// ----------------------------------------------------------------------------
// binary_rectangle_region_stats_tb
// Streams binary images into the rectangle statistics block, one pixel per
// word, and predicts the three records of every image in a local model of
// the corner, run and column tracking. Images are mostly separate filled
// rectangles with random placement, plus noise frames, edge sizes, one full
// row and one full column at clamped register values. Both sides of the
// pixel and result channels stall at random, and one long result stall
// backs up the pixel input.
// ----------------------------------------------------------------------------

module binary_rectangle_region_stats_tb;
    import brrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM       = 64;
    localparam int SETTLE_CYCLES = MAX_DIM + 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        bit                valid;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [LEN_W-1:0]  w;
        logic [LEN_W-1:0]  h;
        logic [AREA_W-1:0] area;
    } rect_t;

    typedef struct {
        measure_kind_t     kind;
        logic              found;
        logic [POS_W-1:0]  top_row;
        logic [POS_W-1:0]  left_col;
        logic [LEN_W-1:0]  width;
        logic [LEN_W-1:0]  height;
        logic [AREA_W-1:0] area;
        logic              last;
    } stats_word_t;

    logic clk = 1'b0;
    logic rst_n;

    brrs_pixel_if  pixels_if();
    brrs_cfg_if    cfg_if();
    brrs_result_if results_if();

    binary_rectangle_region_stats #(.MAX_DIM(MAX_DIM)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels_if),
        .cfg     (cfg_if),
        .results (results_if)
    );

    // Model state: register copies and per-image tracking
    logic [CFG_DATA_W-1:0] rows_cfg = DIM_RESET;
    logic [CFG_DATA_W-1:0] cols_cfg = DIM_RESET;
    bit                    above_row [MAX_DIM];
    bit                    col_open  [MAX_DIM];
    logic [POS_W-1:0]      open_top  [MAX_DIM];
    logic [LEN_W-1:0]      open_wid  [MAX_DIM];
    logic [POS_W-1:0]      row_pos;
    logic [POS_W-1:0]      col_pos;
    bit                    left_set;
    logic [POS_W-1:0]      run_col;
    logic [LEN_W-1:0]      run_len;
    rect_t                 best [NUM_KINDS];

    stats_word_t expected_stats[$];
    bit          frame [MAX_DIM][MAX_DIM];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int pixels_sent;
    int fail_count;
    int quiet_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_image();
        for (int k = 0; k < MAX_DIM; k++)
        begin
            above_row[k] = 1'b0;
            col_open[k]  = 1'b0;
            open_top[k]  = '0;
            open_wid[k]  = '0;
        end
        row_pos  = '0;
        col_pos  = '0;
        left_set = 1'b0;
        run_col  = '0;
        run_len  = '0;
        for (int k = 0; k < NUM_KINDS; k++)
            best[k] = '{default: '0};
    endfunction

    function automatic int effective_dim(logic [CFG_DATA_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int kind_value(rect_t r, int k);
        if (k == KIND_WIDTH)
            return int'(r.w);
        if (k == KIND_AREA)
            return int'(r.area);
        return int'(r.h);
    endfunction

    // Keep a candidate per measure; ties go to the earlier corner
    function automatic void rank_rectangle(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                           logic [LEN_W-1:0] w, logic [LEN_W-1:0] h);
        rect_t cand;
        bit    take;
        int    nv;
        int    ov;
        cand.valid = 1'b1;
        cand.row   = row;
        cand.col   = col;
        cand.w     = w;
        cand.h     = h;
        cand.area  = AREA_W'(w) * AREA_W'(h);
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            nv = kind_value(cand, k);
            ov = kind_value(best[k], k);
            if (!best[k].valid)
                take = 1'b1;
            else if (nv > ov)
                take = 1'b1;
            else if (nv == ov)
                take = (row < best[k].row) || (row == best[k].row && col < best[k].col);
            else
                take = 1'b0;
            if (take)
                best[k] = cand;
        end
    endfunction

    // Record the width of a run that started on a corner of this row
    function automatic void close_run();
        if (run_len > 0 && col_open[run_col] && open_top[run_col] == row_pos)
            open_wid[run_col] = run_len;
        run_len = '0;
    endfunction

    function automatic void retire_column(int c, int end_row);
        rank_rectangle(open_top[c], POS_W'(c), open_wid[c],
                       LEN_W'(end_row - int'(open_top[c])));
        col_open[c] = 1'b0;
    endfunction

    // Advance the model by one accepted pixel
    function automatic void scan_pixel(bit p);
        int          rows;
        int          cols;
        int          c;
        stats_word_t e;
        rows = effective_dim(rows_cfg);
        cols = effective_dim(cols_cfg);
        c = int'(col_pos);
        if (c >= MAX_DIM)
            c = MAX_DIM - 1;

        if (col_open[c] && !p)
            retire_column(c, int'(row_pos));

        if (p && !above_row[c] && !left_set)
        begin
            col_open[c] = 1'b1;
            open_top[c] = row_pos;
            open_wid[c] = LEN_W'(1);
        end

        if (p)
        begin
            if (!left_set)
            begin
                run_col = POS_W'(c);
                run_len = LEN_W'(1);
            end
            else
                run_len = run_len + LEN_W'(1);
        end
        else if (left_set)
            close_run();

        above_row[c] = p;
        left_set     = p;

        if (int'(col_pos) + 1 < cols)
        begin
            col_pos = col_pos + POS_W'(1);
            return;
        end

        // End of row
        close_run();
        left_set = 1'b0;
        col_pos  = '0;
        if (int'(row_pos) + 1 < rows)
        begin
            row_pos = row_pos + POS_W'(1);
            return;
        end

        // End of image: complete open columns, then queue the three records
        for (int k = 0; k < MAX_DIM; k++)
            if (col_open[k])
                retire_column(k, int'(row_pos) + 1);

        for (int k = 0; k < NUM_KINDS; k++)
        begin
            e.kind     = measure_kind_t'(k);
            e.found    = best[k].valid;
            e.top_row  = best[k].valid ? best[k].row  : '0;
            e.left_col = best[k].valid ? best[k].col  : '0;
            e.width    = best[k].valid ? best[k].w    : '0;
            e.height   = best[k].valid ? best[k].h    : '0;
            e.area     = best[k].valid ? best[k].area : '0;
            e.last     = (k == NUM_KINDS - 1);
            expected_stats.push_back(e);
        end
        clear_image();
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        stats_word_t e;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_stats.size() == 0)
            begin
                $error("result word with no record pending");
                fail_count++;
            end
            else
            begin
                e = expected_stats.pop_front();
                check_field("measure_kind", int'(e.kind), int'(results_if.measure_kind));
                check_field("found", int'(e.found), int'(results_if.found));
                check_field("top_row", int'(e.top_row), int'(results_if.top_row));
                check_field("left_col", int'(e.left_col), int'(results_if.left_col));
                check_field("rect_width", int'(e.width), int'(results_if.rect_width));
                check_field("rect_height", int'(e.height), int'(results_if.rect_height));
                check_field("rect_area", int'(e.area), int'(results_if.rect_area));
                check_field("last", int'(e.last), int'(results_if.last));
            end
        end
    end

    // Drive result ready; a hold-off request forces a long stall
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            results_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            results_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((pixels_if.valid && pixels_if.ready) || (cfg_if.valid && cfg_if.ready) ||
                 (results_if.valid && results_if.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic send_pixel(bit p);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pixels_if.valid <= 1'b0;
            @(negedge clk);
        end
        pixels_if.valid <= 1'b1;
        pixels_if.pixel <= p;
        @(posedge clk);
        while (!pixels_if.ready)
            @(posedge clk);
        pixels_sent++;
        scan_pixel(p);
    endtask

    // Send bits from the top down
    task automatic send_pattern(int count, logic [63:0] bits);
        for (int i = count - 1; i >= 0; i--)
            send_pixel(bits[i]);
    endtask

    task automatic send_frame(int rows, int cols);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_pixel(frame[r][c]);
    endtask

    // Drop the pixel word, drain all records, then let the sweep finish
    task automatic wait_idle();
        @(negedge clk);
        pixels_if.valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_ROWS: rows_cfg = data;
            REG_IMAGE_COLS: cols_cfg = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_dims(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols);
        wait_idle();
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_IMAGE_COLS, cols);
    endtask

    // Fill the frame with separate rectangles, or with noise of random density
    function automatic void fill_frame(int rows, int cols, bit tidy);
        int  r0;
        int  c0;
        int  h;
        int  w;
        int  density;
        bit  room;
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
                frame[r][c] = 1'b0;
        if (!tidy)
        begin
            density = $urandom_range(1, 99);
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                    frame[r][c] = ($urandom_range(0, 99) < density);
            return;
        end
        repeat ($urandom_range(1, 8))
        begin
            r0 = $urandom_range(0, rows - 1);
            c0 = $urandom_range(0, cols - 1);
            h  = $urandom_range(1, rows - r0);
            w  = $urandom_range(1, cols - c0);
            room = 1'b1;
            for (int r = r0 - 1; r <= r0 + h; r++)
                for (int c = c0 - 1; c <= c0 + w; c++)
                    if (r >= 0 && r < rows && c >= 0 && c < cols && frame[r][c])
                        room = 1'b0;
            if (room)
                for (int r = r0; r < r0 + h; r++)
                    for (int c = c0; c < c0 + w; c++)
                        frame[r][c] = 1'b1;
        end
    endfunction

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_corner_cases();
        // Zero dimensions act as one: a single set pixel, then an empty image
        write_dims(CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_pixel(1'b1);
        send_pixel(1'b0);
        // Tie: the earlier corner completes last and still wins
        write_dims(CFG_DATA_W'(3), CFG_DATA_W'(3));
        send_pattern(9, 64'b101_100_100);
        // Two rectangles finishing together, equal heights
        write_dims(CFG_DATA_W'(2), CFG_DATA_W'(4));
        send_pattern(8, 64'b1101_1101);
    endtask

    // Stall results for a long stretch while whole images keep coming
    task automatic test_backpressure();
        write_dims(CFG_DATA_W'(1), CFG_DATA_W'(2));
        hold_left = HOLD_CYCLES;
        repeat (8)
        begin
            fill_frame(1, 2, 1'b1);
            send_frame(1, 2);
        end
    endtask

    task automatic test_random_images(int target);
        int                    start;
        int                    rows;
        int                    cols;
        logic [CFG_DATA_W-1:0] rv;
        logic [CFG_DATA_W-1:0] cv;
        start = pixels_sent;
        while (pixels_sent - start < target)
        begin
            rows = $urandom_range(1, 5);
            cols = $urandom_range(1, 7);
            rv = CFG_DATA_W'(rows);
            cv = CFG_DATA_W'(cols);
            if (rows == 1 && $urandom_range(0, 1))
                rv = '0;
            if (cols == 1 && $urandom_range(0, 1))
                cv = '0;
            write_dims(rv, cv);
            repeat ($urandom_range(1, 3))
            begin
                fill_frame(rows, cols, $urandom_range(0, 3) != 0);
                send_frame(rows, cols);
            end
        end
    endtask

    // Oversized column count clamps to 64: one full-width row
    task automatic test_long_row();
        write_dims(CFG_DATA_W'(0), '1);
        repeat (MAX_DIM) send_pixel(1'b1);
    endtask

    // Oversized row count clamps to 64: one full-height column
    task automatic test_long_column();
        write_dims('1, CFG_DATA_W'(0));
        repeat (MAX_DIM) send_pixel(1'b1);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        pixels_if.valid  = 1'b0;
        pixels_if.pixel  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.addr      = '0;
        cfg_if.data      = '0;
        results_if.ready = 1'b0;
        hold_left        = 0;
        pixels_sent      = 0;
        fail_count       = 0;
        quiet_cycles     = 0;
        clear_image();
        set_idling(15, 84);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_cases();
        test_backpressure();
        set_idling(84, 15);
        test_random_images(8);
        test_long_row();
        set_idling(0, 0);
        test_long_column();

        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
